// ===== src/uvs_pkg.sv =====
// ----------------------------------------------------------------------------
// uvs_pkg
// Shared widths, angle and fixed-point constants, register indices and lane
// numbering for the UV sphere vertex and index generator.
// ----------------------------------------------------------------------------
package uvs_pkg;

    localparam int ANGLE_W   = 16;
    localparam int SINE_W    = 16;
    localparam int FRAC_W    = 14;
    localparam int NUM_LANES = 4;
    localparam int CFG_AW    = 3;
    localparam int CFG_DW    = 16;
    localparam int INDEX_W   = 16;

    localparam logic [ANGLE_W-1:0] QUARTER_TURN = 16'h4000;
    localparam logic [63:0]        HALF_PI_Q30  = 64'd1686629713;
    localparam logic [63:0]        Q15_MAX      = 64'd32767;
    localparam logic [63:0]        Q30_HALF     = 64'd536870912;

    localparam int LANE_RING_SIN = 0;
    localparam int LANE_RING_COS = 1;
    localparam int LANE_SEG_SIN  = 2;
    localparam int LANE_SEG_COS  = 3;

    localparam logic [CFG_AW-1:0] REG_RADIUS    = 3'd0;
    localparam logic [CFG_AW-1:0] REG_RINGS     = 3'd1;
    localparam logic [CFG_AW-1:0] REG_SEGMENTS  = 3'd2;
    localparam logic [CFG_AW-1:0] REG_RING_STEP = 3'd3;
    localparam logic [CFG_AW-1:0] REG_SEG_STEP  = 3'd4;

endpackage

// ===== src/uvs_sine_lut.sv =====
// ----------------------------------------------------------------------------
// uvs_sine_lut
// Four-lane sine lookup on a quarter-wave Q1.15 table built at elaboration,
// with nearest-entry selection, quadrant folding and a registered result.
// ----------------------------------------------------------------------------
module uvs_sine_lut #(
    parameter int SINE_TABLE_DEPTH = 256
) (
    input  logic                                                  i_clk,
    input  logic                                                  i_en,
    input  logic [uvs_pkg::NUM_LANES-1:0][uvs_pkg::ANGLE_W-1:0]   i_angle,
    output logic [uvs_pkg::NUM_LANES-1:0][uvs_pkg::SINE_W-1:0]    o_sine
);
    import uvs_pkg::*;

    localparam int IW = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int PW = FRAC_W + IW;

    logic [SINE_W-2:0] w_tab [SINE_TABLE_DEPTH+1];

    for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_tab
        localparam logic [63:0] X  = (HALF_PI_Q30 * 64'(k)) / 64'(SINE_TABLE_DEPTH);
        localparam logic [63:0] X2 = (X * X) >> 30;
        localparam logic [63:0] T1 = ((X * X2) >> 30) / 64'd6;
        localparam logic [63:0] T2 = ((T1 * X2) >> 30) / 64'd20;
        localparam logic [63:0] T3 = ((T2 * X2) >> 30) / 64'd42;
        localparam logic [63:0] T4 = ((T3 * X2) >> 30) / 64'd72;
        localparam logic [63:0] T5 = ((T4 * X2) >> 30) / 64'd110;
        localparam logic [63:0] AC = X - T1 + T2 - T3 + T4 - T5;
        localparam logic [63:0] VR = (AC * Q15_MAX + Q30_HALF) >> 30;
        localparam logic [63:0] V  = (VR > Q15_MAX) ? Q15_MAX : VR;
        assign w_tab[k] = V[SINE_W-2:0];
    end

    logic [PW-1:0]     w_prod [NUM_LANES];
    logic [IW-1:0]     w_near [NUM_LANES];
    logic [IW-1:0]     w_idx  [NUM_LANES];
    logic [SINE_W-1:0] w_mag  [NUM_LANES];
    logic [NUM_LANES-1:0][SINE_W-1:0] n_sine;

    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            w_prod[l] = PW'(i_angle[l][FRAC_W-1:0]) * PW'(SINE_TABLE_DEPTH)
                      + PW'(1 << (FRAC_W - 1));
            w_near[l] = w_prod[l][PW-1:FRAC_W];
            if (w_near[l] > IW'(SINE_TABLE_DEPTH)) begin
                w_near[l] = IW'(SINE_TABLE_DEPTH);
            end
            w_idx[l] = i_angle[l][FRAC_W] ? IW'(SINE_TABLE_DEPTH) - w_near[l] : w_near[l];
            w_mag[l] = {1'b0, w_tab[w_idx[l]]};
            n_sine[l] = i_angle[l][FRAC_W+1] ? SINE_W'(-w_mag[l]) : w_mag[l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_sine <= n_sine;
        end
    end

endmodule

// ===== src/uv_sphere_vertex_index_gen_top.sv =====
// ----------------------------------------------------------------------------
// uv_sphere_vertex_index_gen_top
// UV sphere grid point to vertex position (Q8.8) and six triangle indices.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  in      | input     | i_in_valid / o_in_ready | i_ring_index, i_segment_index
//  out     | output    | o_out_valid/i_out_ready | o_pos_x/y/z, o_has_indices,
//          |           |                         | o_tri_index_0..5
//  cfg     | input     | i_cfg_we                | i_cfg_addr, i_cfg_wdata
//
//  One item per cycle while no result waits on i_out_ready, through angle and base
//  multiply, table lookup, two multiply stages each followed by rounding.
//  The whole pipeline advances together; it holds while a result waits on
//  i_out_ready, and o_in_ready is low only then.
//  Reset clears the valid bits and loads the register defaults; the sine
//  table is constant logic and needs no fill.
// ----------------------------------------------------------------------------
module uv_sphere_vertex_index_gen_top #(
    parameter int SINE_TABLE_DEPTH = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [uvs_pkg::CFG_AW-1:0]    i_cfg_addr,
    input  logic [uvs_pkg::CFG_DW-1:0]    i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [7:0]                    i_ring_index,
    input  logic [7:0]                    i_segment_index,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [15:0]            o_pos_x,
    output logic signed [15:0]            o_pos_y,
    output logic signed [15:0]            o_pos_z,
    output logic                          o_has_indices,
    output logic [15:0]                   o_tri_index_0,
    output logic [15:0]                   o_tri_index_1,
    output logic [15:0]                   o_tri_index_2,
    output logic [15:0]                   o_tri_index_3,
    output logic [15:0]                   o_tri_index_4,
    output logic [15:0]                   o_tri_index_5
);
    import uvs_pkg::*;

    localparam int STAGES = 6;

    typedef struct packed {
        logic               has;
        logic [INDEX_W-1:0] base;
        logic [INDEX_W-1:0] base_n;
        logic [INDEX_W-1:0] base_n1;
        logic [INDEX_W-1:0] base_1;
    } t_idx;

    function automatic logic signed [15:0] f_round_q15(input logic signed [31:0] p);
        logic [31:0] m;
        logic [31:0] s;
        logic [15:0] r;
        m = p[31] ? 32'(-p) : 32'(p);
        s = (m + 32'd16384) >> 15;
        r = s[15:0];
        return p[31] ? $signed(16'(-r)) : $signed(r);
    endfunction

    logic [14:0]        r_radius;
    logic [7:0]         r_ring_count;
    logic [7:0]         r_segment_count;
    logic [ANGLE_W-1:0] r_ring_step;
    logic [ANGLE_W-1:0] r_seg_step;

    logic [STAGES-1:0]  r_vld;
    logic               w_en;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius        <= 15'd256;
            r_ring_count    <= 8'd16;
            r_segment_count <= 8'd16;
            r_ring_step     <= 16'd2048;
            r_seg_step      <= 16'd4096;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_RADIUS:    r_radius        <= i_cfg_wdata[14:0];
                REG_RINGS:     r_ring_count    <= i_cfg_wdata[7:0];
                REG_SEGMENTS:  r_segment_count <= i_cfg_wdata[7:0];
                REG_RING_STEP: r_ring_step     <= i_cfg_wdata;
                REG_SEG_STEP:  r_seg_step      <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign w_en       = !r_vld[STAGES-1] || i_out_ready;
    assign o_in_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[STAGES-2:0], i_in_valid};
        end
    end

    // stage 1: angles and base index
    logic [NUM_LANES-1:0][ANGLE_W-1:0] r1_angle;
    logic [INDEX_W-1:0]                r1_base;
    logic                              r1_has;
    logic [ANGLE_W-1:0]                n1_ra;
    logic [ANGLE_W-1:0]                n1_sa;

    assign n1_ra = ANGLE_W'(i_ring_index * r_ring_step);
    assign n1_sa = ANGLE_W'(i_segment_index * r_seg_step);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_angle[LANE_RING_SIN] <= n1_ra;
            r1_angle[LANE_RING_COS] <= n1_ra + QUARTER_TURN;
            r1_angle[LANE_SEG_SIN]  <= n1_sa;
            r1_angle[LANE_SEG_COS]  <= n1_sa + QUARTER_TURN;
            r1_base <= INDEX_W'(i_ring_index * ({1'b0, r_segment_count} + 9'd1)
                                + 17'(i_segment_index));
            r1_has  <= i_ring_index != r_ring_count;
        end
    end

    // stage 2: sine lookup and index sums
    logic [NUM_LANES-1:0][SINE_W-1:0] w_sine;
    t_idx                             r2_idx;
    t_idx                             n2_idx;
    logic [INDEX_W-1:0]               w_n;

    uvs_sine_lut #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_sine (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (r1_angle),
        .o_sine  (w_sine)
    );

    assign w_n = INDEX_W'(r_segment_count);

    always_comb begin
        n2_idx.has     = r1_has;
        n2_idx.base    = r1_base;
        n2_idx.base_n  = r1_base + w_n;
        n2_idx.base_n1 = r1_base + w_n + 16'd1;
        n2_idx.base_1  = r1_base + 16'd1;
        if (!r1_has) begin
            n2_idx = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_idx <= n2_idx;
        end
    end

    // stage 3: ring products
    logic signed [31:0] r3_pr0;
    logic signed [31:0] r3_py0;
    logic signed [15:0] r3_sin_sa;
    logic signed [15:0] r3_cos_sa;
    t_idx               r3_idx;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_pr0    <= $signed({1'b0, r_radius}) * $signed(w_sine[LANE_RING_SIN]);
            r3_py0    <= $signed({1'b0, r_radius}) * $signed(w_sine[LANE_RING_COS]);
            r3_sin_sa <= $signed(w_sine[LANE_SEG_SIN]);
            r3_cos_sa <= $signed(w_sine[LANE_SEG_COS]);
            r3_idx    <= r2_idx;
        end
    end

    // stage 4: round ring products
    logic signed [15:0] r4_r0;
    logic signed [15:0] r4_y0;
    logic signed [15:0] r4_sin_sa;
    logic signed [15:0] r4_cos_sa;
    t_idx               r4_idx;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_r0     <= f_round_q15(r3_pr0);
            r4_y0     <= f_round_q15(r3_py0);
            r4_sin_sa <= r3_sin_sa;
            r4_cos_sa <= r3_cos_sa;
            r4_idx    <= r3_idx;
        end
    end

    // stage 5: segment products
    logic signed [31:0] r5_px;
    logic signed [31:0] r5_pz;
    logic signed [15:0] r5_y0;
    t_idx               r5_idx;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_px  <= r4_r0 * r4_sin_sa;
            r5_pz  <= r4_r0 * r4_cos_sa;
            r5_y0  <= r4_y0;
            r5_idx <= r4_idx;
        end
    end

    // stage 6: round and hold for the output transaction
    logic signed [15:0] r_pos_x;
    logic signed [15:0] r_pos_y;
    logic signed [15:0] r_pos_z;
    t_idx               r6_idx;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pos_x <= f_round_q15(r5_px);
            r_pos_y <= r5_y0;
            r_pos_z <= f_round_q15(r5_pz);
            r6_idx  <= r5_idx;
        end
    end

    assign o_out_valid   = r_vld[STAGES-1];
    assign o_pos_x       = r_pos_x;
    assign o_pos_y       = r_pos_y;
    assign o_pos_z       = r_pos_z;
    assign o_has_indices = r6_idx.has;
    assign o_tri_index_0 = r6_idx.base_n1;
    assign o_tri_index_1 = r6_idx.base;
    assign o_tri_index_2 = r6_idx.base_n;
    assign o_tri_index_3 = r6_idx.base_n1;
    assign o_tri_index_4 = r6_idx.base_1;
    assign o_tri_index_5 = r6_idx.base;

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input taken while output stalled");

    a_pipe_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[STAGES-2] && o_in_ready |=> o_out_valid)
        else $error("transaction lost in final stage");

    a_last_ring_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_has_indices |->
            o_tri_index_0 == 16'd0 && o_tri_index_2 == 16'd0 && o_tri_index_4 == 16'd0)
        else $error("indices not cleared on last ring");

    a_index_relation: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_has_indices |->
            o_tri_index_4 == 16'(o_tri_index_1 + 16'd1) &&
            o_tri_index_0 == 16'(o_tri_index_2 + 16'd1))
        else $error("triangle indices inconsistent");

endmodule
